// ===== hw/rtl/utf8_to_utf16le_transcoder_defines.svh =====
// assertion macros shared by the transcoder rtl
`ifndef UTF8_TO_UTF16LE_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16LE_TRANSCODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define U8U16_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("u8u16 check failed");
`define U8U16_ASSERT_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`else
`define U8U16_ASSERT(label, prop)
`define U8U16_ASSERT_MSG(label, prop, msg)
`endif

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT       = 16'hFFFD;
	localparam logic [20:0] MAX_CODE_POINT  = 21'h10FFFF;
	localparam logic [20:0] SURR_FIRST      = 21'h00D800;
	localparam logic [20:0] SURR_LAST       = 21'h00DFFF;
	localparam logic [15:0] HIGH_SURR_BASE  = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE   = 16'hDC00;
	localparam logic [20:0] SUPP_BASE       = 21'h010000;
	localparam logic [20:0] MIN_TWO_BYTE    = 21'h000080;
	localparam logic [20:0] MIN_THREE_BYTE  = 21'h000800;

	// pending sequence length codes
	localparam logic [2:0] SEQ_NONE  = 3'd0;
	localparam logic [2:0] SEQ_TWO   = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR  = 3'd4;

	// units caused by one byte: rcount replacement units, then tail_n tail units
	typedef struct packed {
		logic [1:0]  rcount;
		logic [1:0]  tail_n;
		logic [15:0] t0;
		logic        t0_repl;
		logic [15:0] t1;
		logic        eos;
	} bundle_t;

endpackage

// ===== hw/rtl/u8u16_decode.sv =====
`include "utf8_to_utf16le_transcoder_defines.svh"

module u8u16_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           byte_in,
	input  logic                 end_of_string,
	output u8u16_pkg::bundle_t   bundle,
	output logic                 bundle_valid
);

	logic [20:0] pv_q, pv_d;
	logic [2:0]  len_q, len_d;
	logic [1:0]  held_q, held_d;

	logic        pending;
	logic        is_cont;
	logic [20:0] pv_shift;
	logic [1:0]  held_inc;
	logic [20:0] cp_min;
	logic [20:0] cp_off;
	logic [2:0]  lead_len;
	logic [20:0] lead_bits;

	assign pending  = (len_q != u8u16_pkg::SEQ_NONE);
	assign is_cont  = (byte_in[7:6] == 2'b10);
	assign pv_shift = {pv_q[14:0], byte_in[5:0]};
	assign held_inc = held_q + 2'd1;
	assign cp_off   = pv_shift - u8u16_pkg::SUPP_BASE;

	always_comb begin
		case (len_q)
			u8u16_pkg::SEQ_TWO:   cp_min = u8u16_pkg::MIN_TWO_BYTE;
			u8u16_pkg::SEQ_THREE: cp_min = u8u16_pkg::MIN_THREE_BYTE;
			default:              cp_min = u8u16_pkg::SUPP_BASE;
		endcase
	end

	// lead byte class
	always_comb begin
		lead_len  = u8u16_pkg::SEQ_NONE;
		lead_bits = '0;
		if (byte_in[7:5] == 3'b110) begin
			lead_len  = u8u16_pkg::SEQ_TWO;
			lead_bits = {16'd0, byte_in[4:0]};
		end else if (byte_in[7:4] == 4'b1110) begin
			lead_len  = u8u16_pkg::SEQ_THREE;
			lead_bits = {17'd0, byte_in[3:0]};
		end else if (byte_in[7:3] == 5'b11110) begin
			lead_len  = u8u16_pkg::SEQ_FOUR;
			lead_bits = {18'd0, byte_in[2:0]};
		end
	end

	always_comb begin
		pv_d           = pv_q;
		len_d          = len_q;
		held_d         = held_q;
		bundle.rcount  = 2'd0;
		bundle.tail_n  = 2'd0;
		bundle.t0      = '0;
		bundle.t0_repl = 1'b0;
		bundle.t1      = '0;
		bundle.eos     = end_of_string;
		if (pending && is_cont) begin
			pv_d   = pv_shift;
			held_d = held_inc;
			if (({1'b0, held_inc} + 3'd1) == len_q) begin
				bundle.tail_n = 2'd1;
				if (pv_shift < cp_min || pv_shift > u8u16_pkg::MAX_CODE_POINT ||
						(pv_shift >= u8u16_pkg::SURR_FIRST &&
						pv_shift <= u8u16_pkg::SURR_LAST)) begin
					bundle.t0      = u8u16_pkg::REPL_UNIT;
					bundle.t0_repl = 1'b1;
				end else if (pv_shift >= u8u16_pkg::SUPP_BASE) begin
					bundle.tail_n = 2'd2;
					bundle.t0     = u8u16_pkg::HIGH_SURR_BASE + {6'd0, cp_off[19:10]};
					bundle.t1     = u8u16_pkg::LOW_SURR_BASE + {6'd0, cp_off[9:0]};
				end else begin
					bundle.t0 = pv_shift[15:0];
				end
				pv_d   = '0;
				len_d  = u8u16_pkg::SEQ_NONE;
				held_d = 2'd0;
			end else if (end_of_string) begin
				// lead plus every continuation so far, this byte included
				bundle.rcount = held_inc + 2'd1;
			end
		end else begin
			if (pending) begin
				// broken sequence: one replacement per held byte
				bundle.rcount = held_q + 2'd1;
				pv_d          = '0;
				len_d         = u8u16_pkg::SEQ_NONE;
				held_d        = 2'd0;
			end
			if (!byte_in[7]) begin
				bundle.tail_n = 2'd1;
				bundle.t0     = {8'd0, byte_in};
			end else if (lead_len == u8u16_pkg::SEQ_NONE || end_of_string) begin
				bundle.tail_n  = 2'd1;
				bundle.t0      = u8u16_pkg::REPL_UNIT;
				bundle.t0_repl = 1'b1;
			end else begin
				pv_d   = lead_bits;
				len_d  = lead_len;
				held_d = 2'd0;
			end
		end
		if (end_of_string) begin
			pv_d   = '0;
			len_d  = u8u16_pkg::SEQ_NONE;
			held_d = 2'd0;
		end
	end

	assign bundle_valid = (bundle.rcount != 2'd0) || (bundle.tail_n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			len_q  <= u8u16_pkg::SEQ_NONE;
			held_q <= 2'd0;
		end else if (accept) begin
			pv_q   <= pv_d;
			len_q  <= len_d;
			held_q <= held_d;
		end
	end

	`U8U16_ASSERT(a_len_legal, len_q != 3'd1 && len_q <= u8u16_pkg::SEQ_FOUR)
	`U8U16_ASSERT(a_held_below_len, pending |-> ({1'b0, held_q} + 3'd1) < len_q)
	`U8U16_ASSERT_MSG(a_eos_clears, accept && end_of_string |=> !pending, "state left after end of string")
	`U8U16_ASSERT(a_byte_gives_unit, accept && end_of_string |-> bundle_valid)

endmodule

// ===== hw/rtl/u8u16_emit.sv =====
`include "utf8_to_utf16le_transcoder_defines.svh"

module u8u16_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  u8u16_pkg::bundle_t   bundle_in,
	output logic                 ready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          code_unit,
	output logic                 was_replaced,
	output logic                 run_last,
	output logic                 string_done
);

	u8u16_pkg::bundle_t bundle_q;
	logic               valid_q;
	logic [1:0]         idx_q;
	logic [2:0]         total;
	logic               last;

	assign total = {1'b0, bundle_q.rcount} + {1'b0, bundle_q.tail_n};
	assign last  = (({1'b0, idx_q} + 3'd1) == total);
	assign ready = !valid_q || (m_tready && last);

	always_comb begin
		if (idx_q < bundle_q.rcount) begin
			code_unit    = u8u16_pkg::REPL_UNIT;
			was_replaced = 1'b1;
		end else if (idx_q == bundle_q.rcount) begin
			code_unit    = bundle_q.t0;
			was_replaced = bundle_q.t0_repl;
		end else begin
			code_unit    = bundle_q.t1;
			was_replaced = 1'b0;
		end
	end

	assign m_tvalid    = valid_q;
	assign run_last    = last;
	assign string_done = last && bundle_q.eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load && ready) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && m_tready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			bundle_q <= bundle_in;
		end
	end

	`U8U16_ASSERT(a_total_range, valid_q |-> total != 3'd0 && total <= 3'd4)
	`U8U16_ASSERT(a_idx_in_bundle, valid_q |-> {1'b0, idx_q} < total)
	`U8U16_ASSERT_MSG(a_stall_holds, valid_q && !m_tready |=> valid_q && $stable(idx_q), "unit lost on stall")
	`U8U16_ASSERT(a_drain_empties, valid_q && m_tready && last && !load |=> !valid_q)

endmodule

// ===== hw/rtl/utf8_to_utf16le_transcoder.sv =====
// utf-8 to utf-16 transcoder: takes one utf-8 byte per transfer on the s_ side
// (s_tlast marks the final byte of the string) and gives utf-16 code units on
// the m_ side, low byte in m_tdata[7:0] so that a byte-wide serialiser sends
// them little-endian. code points from u+10000 up go out as a high then a low
// surrogate. malformed input comes out as u+fffd with m_tuser[0] set; a good
// u+fffd in the input has it clear. m_tuser[1] marks the last unit caused by
// an input byte and m_tlast the last unit of the string. a lead byte that is
// not the end of the string gives no unit until its sequence completes or
// breaks. rate: a byte is taken in every cycle while each byte gives at most
// one unit and m_tready stays high; a byte that gives more than one unit (a
// surrogate pair, or replacements for a broken sequence, up to four) holds the
// input while the single-unit output register drains that byte's units. the
// first unit of a byte is registered and appears in the cycle after its transfer.
module utf8_to_utf16le_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,   // end_of_string
	// code unit output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic [1:0]  m_tuser,   // [0] was_replaced, [1] run_last
	output logic        m_tlast    // string_done
);

	logic               byte_xfer;
	logic               bundle_valid;
	u8u16_pkg::bundle_t bundle;
	logic               was_replaced;
	logic               run_last;

	// a byte transfers whenever the output register is free or draining its last unit
	assign byte_xfer = s_tvalid && s_tready;

	// sequence state and per-byte unit decode
	u8u16_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (byte_xfer),
		.byte_in       (s_tdata),
		.end_of_string (s_tlast),
		.bundle        (bundle),
		.bundle_valid  (bundle_valid)
	);

	// result register, hands out the byte's units one per transfer
	u8u16_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (byte_xfer && bundle_valid),
		.bundle_in    (bundle),
		.ready        (s_tready),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.code_unit    (m_tdata),
		.was_replaced (was_replaced),
		.run_last     (run_last),
		.string_done  (m_tlast)
	);

	assign m_tuser = {run_last, was_replaced};

endmodule
